/* rtl/scaled_glyph_row_generator_macros.svh */
// assertion helpers, clocked on clk and idle while arst_n is low
`ifndef SCALED_GLYPH_ROW_GENERATOR_MACROS_SVH
`define SCALED_GLYPH_ROW_GENERATOR_MACROS_SVH

// same-cycle implication
`define SGR_ASSERT_NOW(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("sgr assertion failed");

// next-cycle implication
`define SGR_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("sgr assertion failed");

`endif

/* rtl/sgr_pkg.sv */
`default_nettype none
package sgr_pkg;

	localparam int SCALE_W        = 4;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
	localparam int MAX_SCALE_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int GLYPH_COUNT = 42;
	localparam int GLYPH_IDX_W = 6;
	localparam int ROW_IDX_W   = 3;
	localparam int MASK_W      = 64;
	localparam int COORD_W     = 16;

	localparam logic [COORD_W-1:0] DESCENT = 16'd3;
	localparam logic [7:0] CODE_G = 8'h67;
	localparam logic [7:0] CODE_Y = 8'h79;
	localparam logic [ROW_IDX_W-1:0] LAST_GLYPH_ROW = 3'd7;

	typedef struct packed {
		logic                   found;
		logic [GLYPH_IDX_W-1:0] idx;
	} glyph_hit_t;

	typedef struct packed {
		logic [GLYPH_IDX_W-1:0] glyph;
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
	} queue_entry_t;

	localparam logic [7:0] GLYPH_CODE [GLYPH_COUNT] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h28, 8'h29, 8'h3D, 8'h2E, 8'h3F,
		8'h40, 8'h25, 8'h23, 8'h73, 8'h69, 8'h6E, 8'h63, 8'h6F, 8'h74, 8'h61,
		8'h6C, 8'h67, 8'h62, 8'h64, 8'h65, 8'h66, 8'h78, 8'h79, 8'h77, 8'h75,
		8'h6D, 8'h72
	};

	// top row in the upper byte, bit 7 of each byte is the leftmost pixel
	localparam logic [63:0] GLYPH_BITS [GLYPH_COUNT] = '{
		64'h3C42_4242_4242_423C, 64'h1808_0808_0808_0808,
		64'h7E02_027E_4040_407E, 64'h7E02_027E_0202_027E,
		64'h060A_1222_3E02_0202, 64'h7E40_407E_0202_027E,
		64'h7E40_407E_4242_427E, 64'h7E02_0204_0810_2020,
		64'h3C42_423C_4242_423C, 64'h3C42_4242_3E02_0438,
		64'h0000_0808_3E08_0800, 64'h0000_0000_7E00_0000,
		64'h0000_2418_1824_0000, 64'h0204_0408_0810_1020,
		64'h1824_4200_0000_0000, 64'h0408_1010_1010_0804,
		64'h2010_0808_0808_1020, 64'h0000_007E_007E_0000,
		64'h0000_0000_0000_1818, 64'h3C42_0204_0808_0008,
		64'h7E24_2424_2424_2422, 64'h3C24_243C_0000_0000,
		64'h3F20_2020_2020_A060, 64'h0000_003E_403C_027C,
		64'h0000_1000_1010_1010, 64'h0000_0078_4444_4444,
		64'h0000_003E_4040_403E, 64'h0000_003C_4242_423C,
		64'h0000_107C_1010_100C, 64'h0000_003C_4242_3E02,
		64'h0010_1010_1010_1010, 64'h003E_4242_3E02_0438,
		64'h0040_4040_7C42_427C, 64'h0002_0202_3E42_423E,
		64'h0000_003C_427C_403C, 64'h0000_3E40_7C40_4040,
		64'h0000_4428_1028_4400, 64'h0022_221E_0204_3800,
		64'h0000_0054_5454_5428, 64'h0000_0042_4242_3E02,
		64'h0000_0040_7E52_5252, 64'h0000_0020_3C22_2020
	};

	function automatic glyph_hit_t glyph_find(input logic [7:0] code);
		glyph_hit_t hit;
		hit = '0;
		for (int g = 0; g < GLYPH_COUNT; g++) begin
			if (code == GLYPH_CODE[g]) begin
				hit.found = 1'b1;
				hit.idx   = GLYPH_IDX_W'(g);
			end
		end
		return hit;
	endfunction

	function automatic logic [7:0] glyph_row(input logic [GLYPH_IDX_W-1:0] idx,
		input logic [ROW_IDX_W-1:0] row);
		logic [63:0] bits;
		bits = (idx < GLYPH_IDX_W'(GLYPH_COUNT)) ? GLYPH_BITS[idx] : '0;
		return bits[(7 - row) * 8 +: 8];
	endfunction

	// each pixel repeated scale times, leftmost pixel at mask bit 0
	function automatic logic [MASK_W-1:0] widen_row(input logic [7:0] bits,
		input logic [SCALE_W-1:0] scale);
		logic [MASK_W-1:0] mask;
		int pos;
		mask = '0;
		for (int col = 0; col < 8; col++) begin
			for (int k = 0; k < 8; k++) begin
				pos = col * int'(scale) + k;
				if (bits[7 - col] && (k < int'(scale)))
					mask[pos[5:0]] = 1'b1;
			end
		end
		return mask;
	endfunction

endpackage
`default_nettype wire

/* rtl/sgr_ifs.sv */
`default_nettype none
interface sgr_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  char_code;
	logic [15:0] origin_x;
	logic [15:0] origin_y;

	modport source (output valid, char_code, origin_x, origin_y, input ready);
	modport sink (input valid, char_code, origin_x, origin_y, output ready);
endinterface

interface sgr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] row_y;
	logic [15:0] row_x;
	logic [63:0] pixel_mask;
	logic        last_row;

	modport source (output valid, row_y, row_x, pixel_mask, last_row, input ready);
	modport sink (input valid, row_y, row_x, pixel_mask, last_row, output ready);
endinterface
`default_nettype wire

/* rtl/sgr_ram.sv */
`default_nettype none
module sgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/scaled_glyph_row_generator.sv */
`default_nettype none
// Scaled glyph row generator. Each accepted word names a character and the top-left corner
// of its cell; the block draws that glyph from a built-in 8x8 font of 42 symbols, scaled by
// pixel_scale (saturated at MAX_SCALE), and sends one word per scan row: 8*scale rows, top
// first, with a pixel mask of 8*scale bits, the row position and a last flag on the final
// row. 'g' and 'y' sit three pixels lower. Unknown codes and scale zero yield nothing. A
// glyph is sent one row per cycle while the receiver is ready, with no gap between glyphs;
// accepted glyphs wait in a QUEUE_DEPTH-entry queue memory whose registered read is hidden
// by a prefetch register, so input is taken every cycle while the queue has room.
// pixel_scale may be written only while the block is idle.
module scaled_glyph_row_generator #(
	parameter int MAX_SCALE   = sgr_pkg::MAX_SCALE_DEF,
	parameter int QUEUE_DEPTH = sgr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sgr_pkg::SCALE_W-1:0] cfg_wdata,
	sgr_in_if.sink                           glyph_in,
	sgr_out_if.source                        row_out
);
	import sgr_pkg::*;

	`include "scaled_glyph_row_generator_macros.svh"

	localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SUB_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int QW    = $bits(queue_entry_t);

	logic [SCALE_W-1:0] pixel_scale_q;
	logic [SCALE_W-1:0] scale_eff;
	logic [SCALE_W-1:0] scale_dec;
	logic [SUB_W-1:0]   scale_m1;

	glyph_hit_t   hit;
	queue_entry_t push_entry;
	queue_entry_t rd_entry;
	logic [QW-1:0] rdata;
	logic         push;
	logic         rd_issue;

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fifo_cnt_q;
	logic          rd_pend_q;

	queue_entry_t nxt_q;
	logic         nxt_valid_q;
	logic         load;

	logic                   busy_q;
	logic [GLYPH_IDX_W-1:0] glyph_q;
	logic [COORD_W-1:0]     x_q;
	logic [COORD_W-1:0]     y_q;
	logic [ROW_IDX_W-1:0]   row_q;
	logic [SUB_W-1:0]       sub_q;
	logic                   gen;
	logic                   gen_last;

	logic               out_valid_q;
	logic [COORD_W-1:0] out_y_q;
	logic [COORD_W-1:0] out_x_q;
	logic [MASK_W-1:0]  out_mask_q;
	logic               out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			pixel_scale_q <= cfg_wdata;
		end
	end

	assign scale_eff = (pixel_scale_q > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
		: pixel_scale_q;
	assign scale_dec = scale_eff - 1'b1;
	assign scale_m1  = scale_dec[SUB_W-1:0];

	// lookup at the input; words that draw nothing never enter the queue
	assign hit  = glyph_find(glyph_in.char_code);
	assign push = glyph_in.valid && glyph_in.ready && hit.found && (scale_eff != '0);

	always_comb begin
		push_entry.glyph = hit.idx;
		push_entry.x     = glyph_in.origin_x;
		push_entry.y     = ((glyph_in.char_code == CODE_G) || (glyph_in.char_code == CODE_Y))
			? glyph_in.origin_y + DESCENT : glyph_in.origin_y;
	end

	assign glyph_in.ready = (fifo_cnt_q != CW'(QUEUE_DEPTH));
	assign rd_issue       = (fifo_cnt_q != '0) && !rd_pend_q && !nxt_valid_q;

	sgr_ram #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (push),
		.waddr (wr_ptr_q),
		.wdata (push_entry),
		.re    (rd_issue),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	assign rd_entry = rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			rd_pend_q  <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_issue)
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			fifo_cnt_q <= fifo_cnt_q + CW'(push) - CW'(rd_issue);
			rd_pend_q  <= rd_issue;
		end
	end

	// prefetch slot between queue read data and the row walker
	assign gen      = busy_q && (!out_valid_q || row_out.ready);
	assign gen_last = gen && (row_q == LAST_GLYPH_ROW) && (sub_q == scale_m1);
	assign load     = nxt_valid_q && (!busy_q || gen_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_valid_q <= 1'b0;
		end else if (rd_pend_q) begin
			nxt_valid_q <= 1'b1;
		end else if (load) begin
			nxt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q)
			nxt_q <= rd_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (gen_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q <= nxt_q.glyph;
			x_q     <= nxt_q.x;
			y_q     <= nxt_q.y;
			row_q   <= '0;
			sub_q   <= '0;
		end else if (gen) begin
			y_q <= y_q + 1'b1;
			if (sub_q == scale_m1) begin
				sub_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				sub_q <= sub_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (gen) begin
			out_valid_q <= 1'b1;
		end else if (row_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			out_y_q    <= y_q;
			out_x_q    <= x_q;
			out_mask_q <= widen_row(glyph_row(glyph_q, row_q), scale_eff);
			out_last_q <= (row_q == LAST_GLYPH_ROW) && (sub_q == scale_m1);
		end
	end

	assign row_out.valid      = out_valid_q;
	assign row_out.row_y      = out_y_q;
	assign row_out.row_x      = out_x_q;
	assign row_out.pixel_mask = out_mask_q;
	assign row_out.last_row   = out_last_q;

	`SGR_ASSERT_NOW(a_queue_bound, 1'b1, fifo_cnt_q <= CW'(QUEUE_DEPTH))
	`SGR_ASSERT_NOW(a_prefetch_free, rd_pend_q, !nxt_valid_q)
	`SGR_ASSERT_NEXT(a_row_advance, gen && !gen_last && !load,
		busy_q && (y_q == $past(y_q) + 1'b1))
	`SGR_ASSERT_NEXT(a_last_flag, gen_last, out_valid_q && out_last_q)

endmodule
`default_nettype wire

/* tb/scaled_glyph_row_generator_tb.sv */
`timescale 1ns / 1ps

module scaled_glyph_row_generator_tb;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 1_500_000;
	localparam int RAND_PHASES   = 6;
	localparam int PHASE_ITEMS   = 50;
	localparam int CALM_ITEMS    = 30;
	localparam int PRESS_ITEMS   = 12;
	localparam int MAX_REPORTS   = 20;

	typedef struct packed {
		logic [15:0] y;
		logic [15:0] x;
		logic [63:0] mask;
		logic        last;
	} scan_row_t;

	class glyph_scoreboard;
		scan_row_t   rows_due[$];
		int unsigned scale;
		int          errors;
		int          glyphs_taken;
		int          rows_checked;

		function new();
			scale        = sgr_pkg::SCALE_RESET;
			errors       = 0;
			glyphs_taken = 0;
			rows_checked = 0;
		endfunction

		function void set_scale(logic [3:0] value);
			scale = (value > sgr_pkg::MAX_SCALE_DEF) ? sgr_pkg::MAX_SCALE_DEF : value;
		endfunction

		function int pending();
			return rows_due.size();
		endfunction

		// font rows, top row in the upper byte, bit 7 of a byte is the leftmost pixel
		function logic [63:0] font_rows(logic [7:0] code, output bit hit);
			hit = 1'b1;
			case (code)
				"0": return 64'h3C42_4242_4242_423C;
				"1": return 64'h1808_0808_0808_0808;
				"2": return 64'h7E02_027E_4040_407E;
				"3": return 64'h7E02_027E_0202_027E;
				"4": return 64'h060A_1222_3E02_0202;
				"5": return 64'h7E40_407E_0202_027E;
				"6": return 64'h7E40_407E_4242_427E;
				"7": return 64'h7E02_0204_0810_2020;
				"8": return 64'h3C42_423C_4242_423C;
				"9": return 64'h3C42_4242_3E02_0438;
				"+": return 64'h0000_0808_3E08_0800;
				"-": return 64'h0000_0000_7E00_0000;
				"*": return 64'h0000_2418_1824_0000;
				"/": return 64'h0204_0408_0810_1020;
				"^": return 64'h1824_4200_0000_0000;
				"(": return 64'h0408_1010_1010_0804;
				")": return 64'h2010_0808_0808_1020;
				"=": return 64'h0000_007E_007E_0000;
				".": return 64'h0000_0000_0000_1818;
				"?": return 64'h3C42_0204_0808_0008;
				"@": return 64'h7E24_2424_2424_2422;
				"%": return 64'h3C24_243C_0000_0000;
				"#": return 64'h3F20_2020_2020_A060;
				"s": return 64'h0000_003E_403C_027C;
				"i": return 64'h0000_1000_1010_1010;
				"n": return 64'h0000_0078_4444_4444;
				"c": return 64'h0000_003E_4040_403E;
				"o": return 64'h0000_003C_4242_423C;
				"t": return 64'h0000_107C_1010_100C;
				"a": return 64'h0000_003C_4242_3E02;
				"l": return 64'h0010_1010_1010_1010;
				"g": return 64'h003E_4242_3E02_0438;
				"b": return 64'h0040_4040_7C42_427C;
				"d": return 64'h0002_0202_3E42_423E;
				"e": return 64'h0000_003C_427C_403C;
				"f": return 64'h0000_3E40_7C40_4040;
				"x": return 64'h0000_4428_1028_4400;
				"y": return 64'h0022_221E_0204_3800;
				"w": return 64'h0000_0054_5454_5428;
				"u": return 64'h0000_0042_4242_3E02;
				"m": return 64'h0000_0040_7E52_5252;
				"r": return 64'h0000_0020_3C22_2020;
				default: begin
					hit = 1'b0;
					return '0;
				end
			endcase
		endfunction

		// expands an accepted word into the scan rows it should produce
		function void note_glyph(logic [7:0] code, logic [15:0] ox, logic [15:0] oy);
			logic [63:0] rows;
			logic [7:0]  line;
			logic [63:0] mask;
			logic [15:0] top;
			bit          hit;
			int unsigned n;
			scan_row_t   r;
			glyphs_taken++;
			if (scale == 0)
				return;
			rows = font_rows(code, hit);
			if (!hit)
				return;
			top = oy;
			if (code == sgr_pkg::CODE_G || code == sgr_pkg::CODE_Y)
				top = oy + sgr_pkg::DESCENT;
			n = 0;
			for (int row = 0; row < 8; row++) begin
				line = rows[(7 - row) * 8 +: 8];
				mask = '0;
				for (int col = 0; col < 8; col++)
					if (line[7 - col])
						for (int k = 0; k < scale; k++)
							mask[col * scale + k] = 1'b1;
				for (int sub = 0; sub < scale; sub++) begin
					n++;
					r.y    = top + 16'(row * scale + sub);
					r.x    = ox;
					r.mask = mask;
					r.last = (n == 8 * scale);
					rows_due.push_back(r);
				end
			end
		endfunction

		function void check_row(scan_row_t got);
			scan_row_t want;
			rows_checked++;
			if (rows_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected row, expected none, actual y=%h x=%h mask=%h last=%b",
						$time, got.y, got.x, got.mask, got.last);
				return;
			end
			want = rows_due.pop_front();
			if (got.y !== want.y || got.x !== want.x || got.mask !== want.mask ||
				got.last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: row mismatch, expected y=%h x=%h mask=%h last=%b", $time,
						want.y, want.x, want.mask, want.last);
					$display("%0t:                 actual y=%h x=%h mask=%h last=%b", $time,
						got.y, got.x, got.mask, got.last);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;

	sgr_in_if  glyph_if ();
	sgr_out_if row_if ();

	scaled_glyph_row_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.glyph_in  (glyph_if),
		.row_out   (row_if)
	);

	glyph_scoreboard sb = new();

	string font_set = "0123456789+-*/^()=.?@%#sincotalgbdefxywumr";
	bit    sender_calm;
	bit    sink_calm;
	bit    long_hold;
	int    scales_seen[16];

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && glyph_if.valid && glyph_if.ready)
			sb.note_glyph(glyph_if.char_code, glyph_if.origin_x, glyph_if.origin_y);
		if (arst_n && row_if.valid && row_if.ready)
			sb.check_row('{row_if.row_y, row_if.row_x, row_if.pixel_mask, row_if.last_row});
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		row_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				row_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
				row_if.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				row_if.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_glyph(logic [7:0] code, logic [15:0] ox, logic [15:0] oy);
		if (!sender_calm && $urandom_range(0, 5) == 0) begin
			glyph_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		glyph_if.valid     <= 1'b1;
		glyph_if.char_code <= code;
		glyph_if.origin_x  <= ox;
		glyph_if.origin_y  <= oy;
		do @(posedge clk); while (!glyph_if.ready);
	endtask

	// unknown codes leave nothing to wait for, so give the block time to empty
	task automatic go_idle();
		glyph_if.valid <= 1'b0;
		// let the monitor note the last accepted word first
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(logic [3:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_scale(value);
		scales_seen[value]++;
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'hFFFF - 16'($urandom_range(0, 70));
			1: return 16'h7FFF - 16'($urandom_range(0, 70));
			2: return 16'($urandom_range(0, 70));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_random(int count);
		logic [7:0] code;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8)
				code = font_set[$urandom_range(0, font_set.len() - 1)];
			else
				code = 8'($urandom_range(0, 255));
			send_glyph(code, pick_coord(), pick_coord());
		end
	endtask

	function automatic logic [3:0] pick_scale();
		case ($urandom_range(0, 9))
			6: return 4'($urandom_range(4, 8));
			7: return 4'd0;
			8: return 4'($urandom_range(9, 15));
			default: return 4'($urandom_range(1, 3));
		endcase
	endfunction

	initial begin
		int used;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		glyph_if.valid      <= 1'b0;
		glyph_if.char_code  <= '0;
		glyph_if.origin_x   <= '0;
		glyph_if.origin_y   <= '0;
		sender_calm = 1'b0;
		sink_calm   = 1'b0;
		long_hold   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scale straight out of reset
		scales_seen[sgr_pkg::SCALE_RESET]++;
		send_glyph("0", 16'h0000, 16'h0000);
		send_glyph("8", 16'h7FFF, 16'h8000);
		send_glyph("g", 16'h1234, 16'hFFFE);
		send_glyph("y", 16'h8000, 16'h7FFC);
		send_glyph("x", 16'hFFFF, 16'h0040);
		send_glyph("#", 16'h0010, 16'hFFFF);
		send_glyph(8'h00, 16'hAAAA, 16'h5555);
		send_glyph(8'hFF, 16'h5555, 16'hAAAA);
		send_glyph("A", 16'h0001, 16'h0001);
		send_glyph("?", 16'hFFFF, 16'hFFFF);
		send_glyph("@", 16'h0100, 16'h0200);
		send_glyph("%", 16'h8001, 16'h7FF8);
		send_glyph("m", 16'h0300, 16'h0400);
		go_idle();

		// widest glyphs, with a wrap below the descent
		write_scale(4'd8);
		send_glyph("#", 16'h0020, 16'h0010);
		send_glyph("g", 16'h7FFF, 16'hFFF0);
		send_glyph(8'h80, 16'h0000, 16'h0000);
		send_glyph("y", 16'hFFFF, 16'h7FE0);
		send_glyph("w", 16'h8000, 16'h0000);
		go_idle();

		write_scale(4'd0);
		send_glyph("0", 16'h0000, 16'h0000);
		send_glyph("g", 16'hFFFF, 16'hFFFF);
		go_idle();

		// saturates at the largest scale
		write_scale(4'd15);
		send_glyph("8", 16'h4000, 16'hC000);
		send_glyph("y", 16'h0007, 16'hFFF8);
		go_idle();

		// receiver holds off while words keep coming, so the input backs up
		write_scale(4'd2);
		sender_calm = 1'b1;
		long_hold   = 1'b1;
		send_random(PRESS_ITEMS);
		sender_calm = 1'b0;
		go_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			write_scale(pick_scale());
			send_random(PHASE_ITEMS);
			go_idle();
		end

		// no idling on either side at the end
		sender_calm = 1'b1;
		sink_calm   = 1'b1;
		write_scale(4'($urandom_range(1, 3)));
		send_random(CALM_ITEMS);
		go_idle();

		used = 0;
		foreach (scales_seen[s])
			if (scales_seen[s] != 0)
				used++;
		$display("run covered %0d input words and %0d scan rows", sb.glyphs_taken,
			sb.rows_checked);
		$display("%0d distinct scale settings, incl. zero, full size and saturation", used);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
